### src/spal_pkg.sv
// Shared types and constants for the speed profile acceleration limiter.
package spal_pkg;

	localparam int Q_W       = 32;   // Q16.16 word
	localparam int MUL_W     = 33;   // multiplier operand width
	localparam int PROD_W    = 66;   // multiplier product width
	localparam int SQ_IN_W   = 66;   // square root radicand width
	localparam int SQ_ROOT_W = 33;   // square root result width
	localparam int SQ_CNT_W  = 6;
	localparam int REG_IDX_W = 2;
	localparam int TERM_W    = 63;
	localparam int SUM_W     = 64;

	localparam logic [REG_IDX_W-1:0] REG_MAX_ACCEL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_DECEL = 2'd1;

	localparam logic [Q_W-1:0]    ACCEL_RESET = 32'h0001_0000;
	localparam logic [PROD_W-1:0] TERM_LIMIT  = 66'h0_2000_0000_0000_0000; // a*d above 2^61
	localparam logic [TERM_W-1:0] TERM_CAP    = 63'h4000_0000_0000_0000;   // 2^62

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_CFG   = 2'd1,
		ST_NEG_SPEED = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_START,
		S_INIT,
		S_F_RD,
		S_F_DX,
		S_F_DY,
		S_F_SUM,
		S_F_SEG,
		S_L_AD,
		S_L_PSQ,
		S_L_CSQ,
		S_L_CMP,
		S_L_SQ,
		S_L_WR,
		S_B_RD,
		S_B_LD,
		S_O_RD,
		S_O_LD,
		S_O_WAIT
	} state_t;

endpackage

### src/spal_ram.sv
// Generic single write port, single read port RAM with registered read.
module spal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

### src/spal_mul.sv
// Shared 33x33 unsigned multiplier with registered product.
module spal_mul (
	input  logic                        clk,
	input  logic [spal_pkg::MUL_W-1:0]  a,
	input  logic [spal_pkg::MUL_W-1:0]  b,
	output logic [spal_pkg::PROD_W-1:0] prod_q
);

	import spal_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

### src/spal_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module spal_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [spal_pkg::SQ_IN_W-1:0]   radicand,
	output logic                           busy,
	output logic [spal_pkg::SQ_ROOT_W-1:0] root
);

	import spal_pkg::*;

	localparam int REM_W = SQ_ROOT_W + 3;

	logic [SQ_IN_W-1:0]   rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [SQ_ROOT_W-1:0] root_q;
	logic [SQ_CNT_W-1:0]  cnt_q;
	logic                 busy_q;
	logic [REM_W-1:0]     rem_sh;
	logic [REM_W-1:0]     trial;
	logic                 fits;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_IN_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= SQ_CNT_W'(SQ_ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == SQ_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_IN_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[SQ_ROOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

### src/speed_profile_accel_limiter_unit.sv
// Top level: point store, forward/backward speed limiting sequencer, output run.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | x_pos, y_pos, speed_in, last_point
//  out     | out_valid / out_stall| speed_out, status, last_result
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A point is stored while the store has room. On the last point, if the status is
// OK and at least two points are stored, the block runs a forward and a
// backward pass over the path, else it returns the stored input speeds. Each
// segment length, and each speed limit that binds, comes from the square root
// unit shared by both passes. Each result is held until out_stall is low.
// in_stall is high from the last point until the run is taken.
// Reset clears the point count and error flags; the point stores need no clearing.
module speed_profile_accel_limiter_unit #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [spal_pkg::Q_W-1:0]     x_pos,
	input  logic signed [spal_pkg::Q_W-1:0]     y_pos,
	input  logic signed [spal_pkg::Q_W-1:0]     speed_in,
	input  logic                                last_point,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [spal_pkg::Q_W-1:0]     speed_out,
	output logic [1:0]                          status,
	output logic                                last_result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [spal_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [spal_pkg::Q_W-1:0]            cfg_data
);

	import spal_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	logic [Q_W-1:0]  max_accel_q, max_decel_q;
	logic [CW-1:0]   count_q;
	logic            overflow_q, neg_q;
	status_t         status_q;
	logic            src_work_q;
	logic [AW-1:0]   i_q, j_q;
	logic [Q_W-1:0]  prevx_q, prevy_q, curx_q, cury_q;
	logic [Q_W-1:0]  prev_q, cur_q, res_q;
	logic [MUL_W-1:0]  dy_abs_q, d_q;
	logic [PROD_W-1:0] acc_q;
	logic [TERM_W-1:0] term_q;
	logic [SUM_W-1:0]  sum_q;
	logic            out_valid_q, out_last_q;
	logic [Q_W-1:0]  out_speed_q;

	// memories
	logic            pt_we;
	logic [AW-1:0]   pt_raddr;
	logic [Q_W-1:0]  x_rd, y_rd, spd_rd;
	logic            work_we;
	logic [AW-1:0]   work_waddr, work_raddr;
	logic [Q_W-1:0]  work_wdata, work_rd;
	logic            seg_we;
	logic [MUL_W-1:0] seg_rd;

	// shared units
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [PROD_W-1:0]  prod;
	logic               sq_start, sq_busy;
	logic [SQ_IN_W-1:0] sq_in;
	logic [SQ_ROOT_W-1:0] sq_root;

	logic            in_acc, full, run_calc, at_last_i, at_last_j, bwd_q;
	logic signed [Q_W:0] dx, dy;
	logic [MUL_W-1:0] dx_abs, dy_abs;
	status_t         status_new;

	assign in_acc    = in_valid && !in_stall;
	assign full      = count_q == CW'(MAX_POINTS);
	assign at_last_i = CW'(i_q) == count_q - 1'b1;
	assign at_last_j = CW'(j_q) == count_q - 1'b1;
	assign pt_we     = in_acc && !full;

	assign dx     = $signed({x_rd[Q_W-1], x_rd}) - $signed({prevx_q[Q_W-1], prevx_q});
	assign dy     = $signed({y_rd[Q_W-1], y_rd}) - $signed({prevy_q[Q_W-1], prevy_q});
	assign dx_abs = dx[Q_W] ? MUL_W'(-dx) : MUL_W'(dx);
	assign dy_abs = dy[Q_W] ? MUL_W'(-dy) : MUL_W'(dy);

	always_comb begin
		if (overflow_q) begin
			status_new = ST_OVERFLOW;
		end else if (max_accel_q == '0 || max_decel_q == '0) begin
			status_new = ST_BAD_CFG;
		end else if (neg_q) begin
			status_new = ST_NEG_SPEED;
		end else begin
			status_new = ST_OK;
		end
	end
	assign run_calc = (status_new == ST_OK) && (count_q >= CW'(2));

	spal_ram #(.WIDTH(Q_W), .DEPTH(MAX_POINTS)) u_x_ram (
		.clk(clk), .we(pt_we), .waddr(count_q[AW-1:0]), .wdata(x_pos),
		.raddr(pt_raddr), .rdata_q(x_rd)
	);
	spal_ram #(.WIDTH(Q_W), .DEPTH(MAX_POINTS)) u_y_ram (
		.clk(clk), .we(pt_we), .waddr(count_q[AW-1:0]), .wdata(y_pos),
		.raddr(pt_raddr), .rdata_q(y_rd)
	);
	spal_ram #(.WIDTH(Q_W), .DEPTH(MAX_POINTS)) u_spd_ram (
		.clk(clk), .we(pt_we), .waddr(count_q[AW-1:0]), .wdata(speed_in),
		.raddr(pt_raddr), .rdata_q(spd_rd)
	);
	spal_ram #(.WIDTH(Q_W), .DEPTH(MAX_POINTS)) u_work_ram (
		.clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
		.raddr(work_raddr), .rdata_q(work_rd)
	);
	spal_ram #(.WIDTH(MUL_W), .DEPTH(MAX_POINTS)) u_seg_ram (
		.clk(clk), .we(seg_we), .waddr(i_q), .wdata(sq_root),
		.raddr(i_q), .rdata_q(seg_rd)
	);

	spal_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod));

	spal_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_in),
		.busy(sq_busy), .root(sq_root)
	);

	// sequencer
	always_comb begin
		state_d    = state_q;
		pt_raddr   = i_q;
		work_we    = 1'b0;
		work_waddr = i_q;
		work_wdata = res_q;
		work_raddr = i_q - 1'b1;
		seg_we     = 1'b0;
		mul_a      = dx_abs;
		mul_b      = dx_abs;
		sq_start   = 1'b0;
		sq_in      = {2'b00, sum_q};
		case (state_q)
			S_IDLE: begin
				if (in_acc && last_point) begin
					state_d = S_START;
				end
			end
			S_START: begin
				pt_raddr = '0;
				state_d  = run_calc ? S_INIT : S_O_RD;
			end
			S_INIT: begin
				work_we    = 1'b1;
				work_waddr = '0;
				work_wdata = spd_rd;
				state_d    = S_F_RD;
			end
			S_F_RD: state_d = S_F_DX;
			S_F_DX: state_d = S_F_DY;
			S_F_DY: begin
				mul_a   = dy_abs_q;
				mul_b   = dy_abs_q;
				state_d = S_F_SUM;
			end
			S_F_SUM: begin
				sq_start = 1'b1;
				sq_in    = acc_q + prod;
				state_d  = S_F_SEG;
			end
			S_F_SEG: begin
				if (!sq_busy) begin
					seg_we  = 1'b1;
					state_d = S_L_AD;
				end
			end
			S_L_AD: begin
				mul_a   = MUL_W'(bwd_q ? max_decel_q : max_accel_q);
				mul_b   = d_q;
				state_d = S_L_PSQ;
			end
			S_L_PSQ: begin
				mul_a   = MUL_W'(prev_q);
				mul_b   = MUL_W'(prev_q);
				state_d = S_L_CSQ;
			end
			S_L_CSQ: begin
				mul_a   = MUL_W'(cur_q);
				mul_b   = MUL_W'(cur_q);
				state_d = S_L_CMP;
			end
			S_L_CMP: begin
				if ({2'b00, sum_q} >= prod) begin
					state_d = S_L_WR;
				end else begin
					sq_start = 1'b1;
					state_d  = S_L_SQ;
				end
			end
			S_L_SQ: begin
				if (!sq_busy) begin
					state_d = S_L_WR;
				end
			end
			S_L_WR: begin
				work_we = 1'b1;
				if (bwd_q) begin
					work_waddr = i_q - 1'b1;
					state_d    = (i_q == AW'(1)) ? S_O_RD : S_B_RD;
				end else begin
					state_d = at_last_i ? S_B_RD : S_F_RD;
				end
			end
			S_B_RD: state_d = S_B_LD;
			S_B_LD: state_d = S_L_AD;
			S_O_RD: begin
				pt_raddr   = j_q;
				work_raddr = j_q;
				state_d    = S_O_LD;
			end
			S_O_LD: state_d = S_O_WAIT;
			S_O_WAIT: begin
				if (!out_stall) begin
					state_d = at_last_j ? S_IDLE : S_O_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_accel_q <= ACCEL_RESET;
			max_decel_q <= ACCEL_RESET;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			neg_q       <= 1'b0;
			status_q    <= ST_OK;
			src_work_q  <= 1'b0;
			bwd_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == REG_MAX_ACCEL) begin
				max_accel_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_MAX_DECEL) begin
				max_decel_q <= cfg_data;
			end
			if (in_acc) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
					neg_q   <= neg_q | speed_in[Q_W-1];
				end
			end
			case (state_q)
				S_START: begin
					status_q   <= status_new;
					src_work_q <= run_calc;
					bwd_q      <= 1'b0;
					i_q        <= AW'(1);
					j_q        <= '0;
				end
				S_L_WR: begin
					if (bwd_q) begin
						i_q <= i_q - 1'b1;
					end else if (at_last_i) begin
						bwd_q <= 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_O_LD: out_valid_q <= 1'b1;
				S_O_WAIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						j_q         <= j_q + 1'b1;
						if (at_last_j) begin
							// run delivered; open for the next path
							count_q    <= '0;
							overflow_q <= 1'b0;
							neg_q      <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_INIT: begin
				prevx_q <= x_rd;
				prevy_q <= y_rd;
				prev_q  <= spd_rd;
			end
			S_F_DX: begin
				cur_q    <= spd_rd;
				curx_q   <= x_rd;
				cury_q   <= y_rd;
				dy_abs_q <= dy_abs;
			end
			S_F_DY: acc_q <= prod;
			S_F_SEG: d_q <= sq_root;
			S_L_PSQ: term_q <= (prod > TERM_LIMIT) ? TERM_CAP : {prod[TERM_W-2:0], 1'b0};
			S_L_CSQ: sum_q <= SUM_W'(prod) + SUM_W'(term_q);
			S_L_CMP: res_q <= cur_q;
			S_L_SQ: res_q <= sq_root[Q_W-1:0];
			S_L_WR: begin
				prev_q <= res_q;
				if (!bwd_q) begin
					prevx_q <= curx_q;
					prevy_q <= cury_q;
				end
			end
			S_B_LD: begin
				cur_q <= work_rd;
				d_q   <= seg_rd;
			end
			S_O_LD: begin
				out_speed_q <= src_work_q ? work_rd : spd_rd;
				out_last_q  <= at_last_j;
			end
			default: ;
		endcase
	end

	assign in_stall    = state_q != S_IDLE;
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign speed_out   = out_speed_q;
	assign status      = status_q;
	assign last_result = out_last_q;

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_POINTS);
	endproperty
	assert property (p_count_bound) else $error("point count beyond capacity");

	property p_sqrt_free;
		@(posedge clk) disable iff (!arst_n) sq_start |-> !sq_busy;
	endproperty
	assert property (p_sqrt_free) else $error("square root restarted while busy");

	property p_no_load_during_run;
		@(posedge clk) disable iff (!arst_n) out_valid_q |-> in_stall;
	endproperty
	assert property (p_no_load_during_run) else $error("input open during output run");

	property p_limit_not_above;
		@(posedge clk) disable iff (!arst_n) state_q == S_L_WR |-> res_q <= cur_q;
	endproperty
	assert property (p_limit_not_above) else $error("limited speed above its cap");

endmodule
